### hdl/gbcyi_pkg.sv
// Package for the gyro bias calibration and yaw integration block.
// Holds default parameters, register reset values, codes and the rate scaling function.
// No dependencies.
package gbcyi_pkg;

    // Default parameter values
    localparam int FRACTION_BITS_DEF = 16;
    localparam int YAW_WIDTH_DEF     = 48;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 21;

    localparam logic [CFG_INDEX_W-1:0] REG_EMA_WEIGHT       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_THRESHOLD = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ATTEMPT_LIMIT    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DEADBAND         = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_ESTIMATE = 3'd4;

    // Register reset values
    localparam logic [15:0]        EMA_WEIGHT_RST       = 16'd58982;
    localparam logic [20:0]        SETTLE_THRESHOLD_RST = 21'd6554;
    localparam logic [15:0]        ATTEMPT_LIMIT_RST    = 16'd1000;
    localparam logic [15:0]        DEADBAND_RST         = 16'd105;
    localparam logic signed [8:0]  INITIAL_ESTIMATE_RST = 9'sd100;

    // Field widths
    localparam int RAW_W   = 16;
    localparam int SCALE_W = 9;
    localparam int DT_W    = 24;

    // Commands
    typedef enum logic [1:0] {
        CMD_SAMPLE    = 2'd0,
        CMD_CLEAR_YAW = 2'd1,
        CMD_RESTART   = 2'd2
    } cmd_t;

    // Phase of operation
    typedef enum logic {
        PHASE_RUN = 1'b0,
        PHASE_CAL = 1'b1
    } phase_t;

    // Reciprocal of 131: ceil(2^24 / 131), exact for magnitudes up to 2^15
    localparam logic [16:0] RECIP_131   = 17'd128071;
    localparam int          RECIP_SHIFT = 24;

    // Raw word divided by 131, truncated toward zero
    function automatic logic signed [SCALE_W-1:0] scale_rate(input logic signed [RAW_W-1:0] raw);
        logic [RAW_W:0]    mag;
        logic [RAW_W+17:0] prod;
        logic [SCALE_W-1:0] quot;
        mag  = raw[RAW_W-1] ? (RAW_W+1)'(-$signed({raw[RAW_W-1], raw}))
                            : {1'b0, raw};
        prod = mag * RECIP_131;
        quot = prod[RECIP_SHIFT +: SCALE_W];
        return raw[RAW_W-1] ? $signed(-quot) : $signed(quot);
    endfunction

endpackage

### hdl/gbcyi_ema_lane.sv
// One axis of the calibration average: exponential update and settle test.
// Depends on gbcyi_pkg.
module gbcyi_ema_lane #(
    parameter int FRACTION_BITS = gbcyi_pkg::FRACTION_BITS_DEF
) (
    input  logic signed [FRACTION_BITS+8:0]            avg,
    input  logic signed [gbcyi_pkg::SCALE_W-1:0]       sample,
    input  logic        [15:0]                         weight,
    input  logic        [20:0]                         threshold,
    output logic signed [FRACTION_BITS+8:0]            avg_new,
    output logic                                       settle_ok
);
    localparam int AVG_W  = FRACTION_BITS + 9;
    localparam int PROD_W = AVG_W + 18;
    localparam int CMP_W  = (AVG_W + 1 > 21) ? AVG_W + 1 : 21;

    logic signed [AVG_W-1:0]  sample_fx;
    logic signed [AVG_W:0]    diff;
    logic signed [PROD_W-1:0] prod;
    logic signed [AVG_W:0]    step;
    logic signed [AVG_W:0]    sum;
    logic        [AVG_W:0]    mag;

    // new = sample + floor((avg - sample) * w / 2^16)
    assign sample_fx = {sample, {FRACTION_BITS{1'b0}}};
    assign diff      = (AVG_W+1)'(avg) - (AVG_W+1)'(sample_fx);
    assign prod      = PROD_W'(diff) * PROD_W'($signed({1'b0, weight}));
    assign step      = prod[16 +: AVG_W+1];
    assign sum       = (AVG_W+1)'(sample_fx) + step;
    assign avg_new   = sum[AVG_W-1:0];

    // sample - new is -step; its magnitude against the threshold
    assign mag       = step[AVG_W] ? $unsigned(-step) : $unsigned(step);
    assign settle_ok = CMP_W'(mag) < CMP_W'(threshold);

endmodule

### hdl/gyro_bias_calibrate_yaw_integrate_unit.sv
// Top level of the gyro bias calibration and yaw integration block.
// Depends on gbcyi_pkg and gbcyi_ema_lane.
//
//   channel   ports       direction   contents
//   s_        valid/ready in          command, three raw rates, time step
//   m_        valid/ready out         yaw, phase flags, z bias, scaled z rate
//   cfg_      valid/ready in          register index and write data
//
// The raw words are scaled into an input register, and the average and yaw updates
// run in one pass into the result register. One transfer per cycle is sustained
// while m_ready does not stall the result register; the rate is set by the average
// and yaw accumulate loops. Reset loads the register defaults and starts calibration.
// Input is held off only while both registers are full and m_ready is low.
module gyro_bias_calibrate_yaw_integrate_unit #(
    parameter int FRACTION_BITS = gbcyi_pkg::FRACTION_BITS_DEF,
    parameter int YAW_WIDTH     = gbcyi_pkg::YAW_WIDTH_DEF
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    // input channel
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic [1:0]                               s_command,
    input  logic signed [gbcyi_pkg::RAW_W-1:0]       s_rate_x,
    input  logic signed [gbcyi_pkg::RAW_W-1:0]       s_rate_y,
    input  logic signed [gbcyi_pkg::RAW_W-1:0]       s_rate_z,
    input  logic [gbcyi_pkg::DT_W-1:0]               s_time_step,
    // result channel
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic signed [YAW_WIDTH-1:0]              m_yaw_angle,
    output logic                                     m_calibrating,
    output logic                                     m_settled,
    output logic signed [gbcyi_pkg::SCALE_W-1:0]     m_bias_z,
    output logic signed [gbcyi_pkg::SCALE_W-1:0]     m_scaled_rate_z,
    // configuration
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [gbcyi_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [gbcyi_pkg::CFG_DATA_W-1:0]         cfg_data
);
    localparam int SW     = gbcyi_pkg::SCALE_W;
    localparam int AVG_W  = FRACTION_BITS + 9;
    localparam int RAW_P  = SW + 1 + gbcyi_pkg::DT_W;
    localparam int SHL    = (FRACTION_BITS >= 16) ? FRACTION_BITS - 16 : 0;
    localparam int SHR    = (FRACTION_BITS >= 16) ? 0 : 16 - FRACTION_BITS;
    localparam int INC_W  = RAW_P + SHL;
    localparam int SUM_W  = ((YAW_WIDTH > INC_W) ? YAW_WIDTH : INC_W) + 2;

    localparam logic signed [SUM_W-1:0] YAW_MAX =
        $signed({{(SUM_W-YAW_WIDTH+1){1'b0}}, {(YAW_WIDTH-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] YAW_MIN =
        $signed({{(SUM_W-YAW_WIDTH+1){1'b1}}, {(YAW_WIDTH-1){1'b0}}});

    // Configuration registers
    logic [15:0]        ema_weight_reg;
    logic [20:0]        settle_threshold_reg;
    logic [15:0]        attempt_limit_reg;
    logic [15:0]        deadband_reg;
    logic signed [8:0]  initial_estimate_reg;

    // Input register
    logic               in_valid_reg;
    logic [1:0]         cmd_reg;
    logic signed [SW-1:0] rate_reg [3];
    logic [gbcyi_pkg::DT_W-1:0] dt_reg;

    // Block state
    gbcyi_pkg::phase_t       phase_reg, phase_next;
    logic signed [AVG_W-1:0] avg_reg [3];
    logic signed [AVG_W-1:0] avg_next [3];
    logic [15:0]             count_reg, count_next;
    logic signed [SW-1:0]    bias_reg, bias_next;
    logic                    settle_reg, settle_next;
    logic signed [YAW_WIDTH-1:0] yaw_reg, yaw_next;

    // Result register
    logic                        out_valid_reg;
    logic signed [YAW_WIDTH-1:0] out_yaw_reg;
    logic                        out_cal_reg;
    logic                        out_settled_reg;
    logic signed [SW-1:0]        out_bias_reg;
    logic signed [SW-1:0]        out_rate_reg;

    logic                    advance;
    logic                    is_sample_cal;
    logic                    cal_done;
    logic                    all_ok;
    logic [2:0]              lane_ok;
    logic signed [AVG_W-1:0] lane_avg [3];
    logic [15:0]             count_inc;
    logic signed [AVG_W-1:0] init_avg;

    logic signed [AVG_W:0]   z_avg_ext;
    logic [AVG_W:0]          z_abs;
    logic [SW:0]             z_quot;
    logic signed [SW-1:0]    z_bias_new;

    logic signed [SW:0]      diff_z;
    logic [SW:0]             diff_abs;
    logic [RAW_P-1:0]        inc_raw;
    logic [INC_W-1:0]        inc;
    logic                    above_band;
    logic signed [SUM_W-1:0] yaw_sum;
    logic signed [YAW_WIDTH-1:0] yaw_run;

    // Handshakes
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ema_weight_reg       <= gbcyi_pkg::EMA_WEIGHT_RST;
            settle_threshold_reg <= gbcyi_pkg::SETTLE_THRESHOLD_RST;
            attempt_limit_reg    <= gbcyi_pkg::ATTEMPT_LIMIT_RST;
            deadband_reg         <= gbcyi_pkg::DEADBAND_RST;
            initial_estimate_reg <= gbcyi_pkg::INITIAL_ESTIMATE_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                gbcyi_pkg::REG_EMA_WEIGHT:       ema_weight_reg       <= cfg_data[15:0];
                gbcyi_pkg::REG_SETTLE_THRESHOLD: settle_threshold_reg <= cfg_data[20:0];
                gbcyi_pkg::REG_ATTEMPT_LIMIT:    attempt_limit_reg    <= cfg_data[15:0];
                gbcyi_pkg::REG_DEADBAND:         deadband_reg         <= cfg_data[15:0];
                gbcyi_pkg::REG_INITIAL_ESTIMATE: initial_estimate_reg <= $signed(cfg_data[8:0]);
                default: ;
            endcase
        end
    end

    // Input register: rates are scaled on the way in
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            cmd_reg     <= s_command;
            rate_reg[0] <= gbcyi_pkg::scale_rate(s_rate_x);
            rate_reg[1] <= gbcyi_pkg::scale_rate(s_rate_y);
            rate_reg[2] <= gbcyi_pkg::scale_rate(s_rate_z);
            dt_reg      <= s_time_step;
        end
    end

    // Per-axis average lanes
    for (genvar i = 0; i < 3; i++) begin : g_lane
        gbcyi_ema_lane #(
            .FRACTION_BITS (FRACTION_BITS)
        ) u_lane (
            .avg       (avg_reg[i]),
            .sample    (rate_reg[i]),
            .weight    (ema_weight_reg),
            .threshold (settle_threshold_reg),
            .avg_new   (lane_avg[i]),
            .settle_ok (lane_ok[i])
        );
    end

    assign all_ok    = &lane_ok;
    assign count_inc = count_reg + 16'd1;
    assign init_avg  = {initial_estimate_reg, {FRACTION_BITS{1'b0}}};

    assign is_sample_cal = advance && (cmd_reg == gbcyi_pkg::CMD_SAMPLE)
                           && (phase_reg == gbcyi_pkg::PHASE_CAL);
    assign cal_done      = is_sample_cal && (all_ok || count_inc >= attempt_limit_reg);

    // z bias: new z average truncated toward zero
    assign z_avg_ext  = (AVG_W+1)'(lane_avg[2]);
    assign z_abs      = z_avg_ext[AVG_W] ? $unsigned(-z_avg_ext) : $unsigned(z_avg_ext);
    assign z_quot     = z_abs[AVG_W:FRACTION_BITS];
    assign z_bias_new = z_avg_ext[AVG_W] ? SW'(-z_quot) : SW'(z_quot);

    // Run phase increment: |rate - bias| * dt rescaled, with sign and saturation
    assign diff_z     = (SW+1)'(rate_reg[2]) - (SW+1)'(bias_reg);
    assign diff_abs   = diff_z[SW] ? $unsigned(-diff_z) : $unsigned(diff_z);
    assign inc_raw    = diff_abs * dt_reg;
    assign inc        = (INC_W'(inc_raw) << SHL) >> SHR;
    assign above_band = inc > INC_W'(deadband_reg);
    assign yaw_sum    = (diff_z > 0) ? SUM_W'(yaw_reg) + $signed({1'b0, inc})
                                     : SUM_W'(yaw_reg) - $signed({1'b0, inc});

    always_comb begin
        if (yaw_sum > YAW_MAX) begin
            yaw_run = YAW_MAX[YAW_WIDTH-1:0];
        end else if (yaw_sum < YAW_MIN) begin
            yaw_run = YAW_MIN[YAW_WIDTH-1:0];
        end else begin
            yaw_run = yaw_sum[YAW_WIDTH-1:0];
        end
    end

    // Phase next state
    always_comb begin
        phase_next = phase_reg;
        if (advance && cmd_reg == gbcyi_pkg::CMD_RESTART) begin
            phase_next = gbcyi_pkg::PHASE_CAL;
        end else if (cal_done) begin
            phase_next = gbcyi_pkg::PHASE_RUN;
        end
    end

    // Datapath next state
    always_comb begin
        count_next  = count_reg;
        bias_next   = bias_reg;
        settle_next = settle_reg;
        yaw_next    = yaw_reg;
        for (int i = 0; i < 3; i++) begin
            avg_next[i] = avg_reg[i];
        end
        if (advance) begin
            unique case (gbcyi_pkg::cmd_t'(cmd_reg))
                gbcyi_pkg::CMD_CLEAR_YAW: begin
                    yaw_next = '0;
                end
                gbcyi_pkg::CMD_RESTART: begin
                    count_next = '0;
                    for (int i = 0; i < 3; i++) begin
                        avg_next[i] = init_avg;
                    end
                end
                gbcyi_pkg::CMD_SAMPLE: begin
                    if (phase_reg == gbcyi_pkg::PHASE_CAL) begin
                        count_next = count_inc;
                        for (int i = 0; i < 3; i++) begin
                            avg_next[i] = lane_avg[i];
                        end
                        if (cal_done) begin
                            bias_next   = z_bias_new;
                            settle_next = all_ok;
                            yaw_next    = '0;
                        end
                    end else if (above_band) begin
                        yaw_next = yaw_run;
                    end
                end
                default: ;
            endcase
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= gbcyi_pkg::PHASE_CAL;
            count_reg  <= '0;
            bias_reg   <= '0;
            settle_reg <= 1'b0;
            yaw_reg    <= '0;
            for (int i = 0; i < 3; i++) begin
                avg_reg[i] <= {gbcyi_pkg::INITIAL_ESTIMATE_RST, {FRACTION_BITS{1'b0}}};
            end
        end else begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            bias_reg   <= bias_next;
            settle_reg <= settle_next;
            yaw_reg    <= yaw_next;
            for (int i = 0; i < 3; i++) begin
                avg_reg[i] <= avg_next[i];
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_yaw_reg     <= yaw_next;
            out_cal_reg     <= (phase_next == gbcyi_pkg::PHASE_CAL);
            out_settled_reg <= settle_next;
            out_bias_reg    <= bias_next;
            out_rate_reg    <= rate_reg[2];
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_yaw_angle     = out_yaw_reg;
    assign m_calibrating   = out_cal_reg;
    assign m_settled       = out_settled_reg;
    assign m_bias_z        = out_bias_reg;
    assign m_scaled_rate_z = out_rate_reg;

endmodule
